FILE: rtl/clar_pkg.sv
package clar_pkg;

   // Fraction bits of a unit vector component (Q2.30).
   localparam int UnitBits  = 30;
   // Squared magnitudes.
   localparam int SqW       = 2 * UnitBits;
   // One root bit per stage; the sum of squares stays below 2^62.
   localparam int SqrtSteps = 32;
   localparam int SqrtW     = 64;
   // The root of the sum of squares stays below 2^31.
   localparam int RootW     = UnitBits + 1;
   // The quotient never exceeds 2^30, so it needs one bit more than UnitBits.
   localparam int DivSteps  = UnitBits + 1;
   localparam int RemW      = 2 * UnitBits + 2;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;
   typedef word_type [2:0]     uvec_type;
   typedef wide_type [2:0]     wvec_type;
   typedef wide_type [5:0]     prod_type;

   // Data that rides alongside a vector through a normalising pipeline.
   typedef struct packed {
      logic     bad;
      uvec_type up;
      uvec_type fwd;
      uvec_type rgt;
   } side_type;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_dir_x;
      logic signed [31:0] up_dir_y;
      logic signed [31:0] up_dir_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] right_x;
      logic signed [31:0] right_y;
      logic signed [31:0] right_z;
      logic signed [31:0] cam_up_x;
      logic signed [31:0] cam_up_y;
      logic signed [31:0] cam_up_z;
      logic signed [31:0] back_x;
      logic signed [31:0] back_y;
      logic signed [31:0] back_z;
      logic               degenerate;
   } rsp_type;

endpackage

FILE: rtl/clar_unitize.sv
module clar_unitize (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  clar_pkg::wvec_type  in_vec,
   input  clar_pkg::side_type  in_side,
   output logic                out_valid,
   output logic                out_zero,
   output clar_pkg::uvec_type  out_unit,
   output clar_pkg::side_type  out_side
);
   import clar_pkg::*;

   typedef struct packed {
      side_type         side;
      logic [2:0]       neg;
      logic [2:0][63:0] mag;
   } front_type;

   typedef struct packed {
      side_type                 side;
      logic                     zero;
      logic [2:0]               neg;
      logic [2:0][UnitBits-1:0] m;
   } carry_type;

   function automatic logic [6:0] bit_len(input logic [63:0] x);
      logic [6:0] len;
      len = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            len = 7'(i + 1);
         end
      end
      return len;
   endfunction

   // Magnitudes and signs.
   front_type a_ff, a_in;
   logic      a_valid_ff;

   always_comb begin
      a_in.side = in_side;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = in_vec[i][63];
         a_in.mag[i] = in_vec[i][63] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
      end
   end

   // Largest magnitude.
   front_type   b_ff;
   logic        b_valid_ff;
   logic [63:0] big01, big_in, big_ff;

   always_comb begin
      big01  = (a_ff.mag[0] > a_ff.mag[1]) ? a_ff.mag[0] : a_ff.mag[1];
      big_in = (a_ff.mag[2] > big01) ? a_ff.mag[2] : big01;
   end

   // Bit length of the largest magnitude.
   front_type  c_ff;
   logic       c_valid_ff;
   logic [6:0] len_ff;
   logic       zero_ff;

   // Scale so that the largest magnitude lies in [2^29, 2^30).
   carry_type d_ff, d_in;
   logic      d_valid_ff;

   always_comb begin
      d_in.side = c_ff.side;
      d_in.zero = zero_ff;
      d_in.neg  = c_ff.neg;
      for (int i = 0; i < 3; i++) begin
         if (len_ff > 7'(UnitBits)) begin
            d_in.m[i] = UnitBits'(c_ff.mag[i] >> (len_ff - 7'(UnitBits)));
         end else begin
            d_in.m[i] = UnitBits'(c_ff.mag[i] << (7'(UnitBits) - len_ff));
         end
      end
   end

   // Squares.
   carry_type            e_ff;
   logic                 e_valid_ff;
   logic [2:0][SqW-1:0]  sq_in, sq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SqW'(d_ff.m[i]) * SqW'(d_ff.m[i]);
      end
   end

   // Square root, one result bit per stage. Entry 0 holds the sum of squares.
   logic [SqrtW-1:0] sq_s_ff [0:SqrtSteps];
   logic [SqrtW-1:0] sq_r_ff [0:SqrtSteps];
   carry_type        sq_c_ff [0:SqrtSteps];
   logic [SqrtSteps:0] sq_v_ff;
   logic [SqrtW-1:0] sum_in;

   assign sum_in = SqrtW'(sq_ff[0]) + SqrtW'(sq_ff[1]) + SqrtW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         sq_v_ff[0] <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff       <= a_in;
         b_ff       <= a_ff;
         big_ff     <= big_in;
         c_ff       <= b_ff;
         len_ff     <= bit_len(big_ff);
         zero_ff    <= (big_ff == '0);
         d_ff       <= d_in;
         e_ff       <= d_ff;
         sq_ff      <= sq_in;
         sq_s_ff[0] <= sum_in;
         sq_r_ff[0] <= '0;
         sq_c_ff[0] <= e_ff;
      end
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam logic [SqrtW-1:0] StepBit = SqrtW'(1) << (2 * (SqrtSteps - 1 - k));
      logic [SqrtW-1:0] trial;
      logic [SqrtW-1:0] s_in, r_in;

      always_comb begin
         trial = sq_r_ff[k] + StepBit;
         if (sq_s_ff[k] >= trial) begin
            s_in = sq_s_ff[k] - trial;
            r_in = (sq_r_ff[k] >> 1) + StepBit;
         end else begin
            s_in = sq_s_ff[k];
            r_in = sq_r_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sq_s_ff[k+1] <= s_in;
            sq_r_ff[k+1] <= r_in;
            sq_c_ff[k+1] <= sq_c_ff[k];
         end
      end
   end

   // Restoring division, one quotient bit per stage. Entry 0 holds the
   // rounded dividend (m * 2^30 + n / 2) and the divisor n.
   logic [2:0][RemW-1:0]  dv_r_ff [0:DivSteps];
   logic [2:0][RootW-1:0] dv_q_ff [0:DivSteps];
   logic [RootW-1:0]      dv_n_ff [0:DivSteps];
   carry_type             dv_c_ff [0:DivSteps];
   logic [DivSteps:0]     dv_v_ff;
   logic [RootW-1:0]      root;
   logic [2:0][RemW-1:0]  num_in;

   assign root = sq_r_ff[SqrtSteps][RootW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = RemW'({sq_c_ff[SqrtSteps].m[i], {UnitBits{1'b0}}})
                   + RemW'(root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (enable) begin
         dv_v_ff[0] <= sq_v_ff[SqrtSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dv_r_ff[0] <= num_in;
         dv_q_ff[0] <= '0;
         dv_n_ff[0] <= root;
         dv_c_ff[0] <= sq_c_ff[SqrtSteps];
      end
   end

   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      localparam int Sh = DivSteps - 1 - j;
      logic [RemW-1:0]       dvs;
      logic [2:0][RemW-1:0]  r_in;
      logic [2:0][RootW-1:0] q_in;

      assign dvs = RemW'(dv_n_ff[j]) << Sh;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            q_in[i] = dv_q_ff[j][i];
            if (dv_r_ff[j][i] >= dvs) begin
               r_in[i]     = dv_r_ff[j][i] - dvs;
               q_in[i][Sh] = 1'b1;
            end else begin
               r_in[i] = dv_r_ff[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (enable) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_r_ff[j+1] <= r_in;
            dv_q_ff[j+1] <= q_in;
            dv_n_ff[j+1] <= dv_n_ff[j];
            dv_c_ff[j+1] <= dv_c_ff[j];
         end
      end
   end

   // Restore the signs.
   uvec_type  unit_in, unit_ff;
   logic      o_valid_ff;
   logic      o_zero_ff;
   side_type  o_side_ff;
   word_type  qw;

   always_comb begin
      unit_in = '0;
      qw      = '0;
      for (int i = 0; i < 3; i++) begin
         qw         = word_type'({1'b0, dv_q_ff[DivSteps][i]});
         unit_in[i] = dv_c_ff[DivSteps].neg[i] ? -qw : qw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         o_valid_ff <= dv_v_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         unit_ff   <= unit_in;
         o_zero_ff <= dv_c_ff[DivSteps].zero;
         o_side_ff <= dv_c_ff[DivSteps].side;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_zero  = o_zero_ff;
   assign out_unit  = unit_ff;
   assign out_side  = o_side_ff;

endmodule

FILE: rtl/camera_look_at_rotation_top.sv
// View rotation of a look-at camera.
// Each beat on the req_ channel carries an eye position, a target point and a
// world up direction in signed Q16.16. Each beat on the rsp_ channel carries
// the rows right, camera up and back (the negated forward direction) in
// signed Q2.30, with a degenerate flag that is set, and all rows zero, when
// the target equals the eye or world up is zero or parallel to forward.
// Every request gives exactly one response, in order.
// The pipeline accepts one beat per cycle while req_stall is low. The path
// holds 219 register stages: three normalising units of 71 stages each,
// set mainly by the 32-stage square root and the 31-stage divider, plus the
// difference, cross-product and output registers.
// When rsp_stall is high while a response is presented, the whole pipeline
// holds and req_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears every valid bit; the data registers are not reset.
module camera_look_at_rotation_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  clar_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output clar_pkg::rsp_type  rsp_data
);
   import clar_pkg::*;

   function automatic prod_type cross_products(input uvec_type a, input uvec_type b);
      prod_type p;
      p[0] = wide_type'($signed(a[1])) * wide_type'($signed(b[2]));
      p[1] = wide_type'($signed(a[2])) * wide_type'($signed(b[1]));
      p[2] = wide_type'($signed(a[2])) * wide_type'($signed(b[0]));
      p[3] = wide_type'($signed(a[0])) * wide_type'($signed(b[2]));
      p[4] = wide_type'($signed(a[0])) * wide_type'($signed(b[1]));
      p[5] = wide_type'($signed(a[1])) * wide_type'($signed(b[0]));
      return p;
   endfunction

   function automatic wvec_type cross_diff(input prod_type p);
      wvec_type c;
      c[0] = p[0] - p[1];
      c[1] = p[2] - p[3];
      c[2] = p[4] - p[5];
      return c;
   endfunction

   logic    enable;
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Forward difference.
   wvec_type t0_vec_ff, t0_vec_in;
   side_type t0_side_ff, t0_side_in;
   logic     t0_valid_ff;

   always_comb begin
      t0_vec_in[0] = wide_type'(req_data.target_x) - wide_type'(req_data.eye_x);
      t0_vec_in[1] = wide_type'(req_data.target_y) - wide_type'(req_data.eye_y);
      t0_vec_in[2] = wide_type'(req_data.target_z) - wide_type'(req_data.eye_z);
      t0_side_in       = '0;
      t0_side_in.up[0] = req_data.up_dir_x;
      t0_side_in.up[1] = req_data.up_dir_y;
      t0_side_in.up[2] = req_data.up_dir_z;
   end

   logic     u1_valid, u1_zero;
   uvec_type u1_unit;
   side_type u1_side;

   clar_unitize u_fwd (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (t0_valid_ff),
      .in_vec    (t0_vec_ff),
      .in_side   (t0_side_ff),
      .out_valid (u1_valid),
      .out_zero  (u1_zero),
      .out_unit  (u1_unit),
      .out_side  (u1_side)
   );

   // forward x up direction
   side_type x1_side_ff, x1_side_in;
   prod_type x1_prod_ff, x1_prod_in;
   logic     x1_valid_ff;
   side_type x2_side_ff;
   wvec_type x2_vec_ff, x2_vec_in;
   logic     x2_valid_ff;

   always_comb begin
      x1_side_in     = u1_side;
      x1_side_in.fwd = u1_unit;
      x1_side_in.bad = u1_side.bad | u1_zero;
      x1_prod_in     = cross_products(u1_unit, u1_side.up);
      x2_vec_in      = cross_diff(x1_prod_ff);
   end

   logic     u2_valid, u2_zero;
   uvec_type u2_unit;
   side_type u2_side;

   clar_unitize u_right (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (x2_valid_ff),
      .in_vec    (x2_vec_ff),
      .in_side   (x2_side_ff),
      .out_valid (u2_valid),
      .out_zero  (u2_zero),
      .out_unit  (u2_unit),
      .out_side  (u2_side)
   );

   // right x forward
   side_type x3_side_ff, x3_side_in;
   prod_type x3_prod_ff, x3_prod_in;
   logic     x3_valid_ff;
   side_type x4_side_ff;
   wvec_type x4_vec_ff, x4_vec_in;
   logic     x4_valid_ff;

   always_comb begin
      x3_side_in     = u2_side;
      x3_side_in.rgt = u2_unit;
      x3_side_in.bad = u2_side.bad | u2_zero;
      x3_prod_in     = cross_products(u2_unit, u2_side.fwd);
      x4_vec_in      = cross_diff(x3_prod_ff);
   end

   logic     u3_valid, u3_zero;
   uvec_type u3_unit;
   side_type u3_side;

   clar_unitize u_up (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (x4_valid_ff),
      .in_vec    (x4_vec_ff),
      .in_side   (x4_side_ff),
      .out_valid (u3_valid),
      .out_zero  (u3_zero),
      .out_unit  (u3_unit),
      .out_side  (u3_side)
   );

   always_comb begin
      rsp_in.right_x    = u3_side.rgt[0];
      rsp_in.right_y    = u3_side.rgt[1];
      rsp_in.right_z    = u3_side.rgt[2];
      rsp_in.cam_up_x   = u3_unit[0];
      rsp_in.cam_up_y   = u3_unit[1];
      rsp_in.cam_up_z   = u3_unit[2];
      rsp_in.back_x     = -$signed(u3_side.fwd[0]);
      rsp_in.back_y     = -$signed(u3_side.fwd[1]);
      rsp_in.back_z     = -$signed(u3_side.fwd[2]);
      rsp_in.degenerate = 1'b0;
      // Any zero vector along the way zeroes the whole beat.
      if (u3_side.bad || u3_zero) begin
         rsp_in            = '0;
         rsp_in.degenerate = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff  <= 1'b0;
         x1_valid_ff  <= 1'b0;
         x2_valid_ff  <= 1'b0;
         x3_valid_ff  <= 1'b0;
         x4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         t0_valid_ff  <= req_valid;
         x1_valid_ff  <= u1_valid;
         x2_valid_ff  <= x1_valid_ff;
         x3_valid_ff  <= u2_valid;
         x4_valid_ff  <= x3_valid_ff;
         rsp_valid_ff <= u3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t0_vec_ff  <= t0_vec_in;
         t0_side_ff <= t0_side_in;
         x1_side_ff <= x1_side_in;
         x1_prod_ff <= x1_prod_in;
         x2_side_ff <= x1_side_ff;
         x2_vec_ff  <= x2_vec_in;
         x3_side_ff <= x3_side_in;
         x3_prod_ff <= x3_prod_in;
         x4_side_ff <= x3_side_ff;
         x4_vec_ff  <= x4_vec_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/tb_camera_look_at_rotation_top.sv
`timescale 1ns / 1ps

module tb_camera_look_at_rotation_top;
   import clar_pkg::*;

   // Predicts the view rotation of one camera set-up and keeps the rotations in flight.
   class rotation_scoreboard;
      rsp_type pending_rotations[$];
      int      mismatches;

      function automatic logic [63:0] magnitude(logic signed [63:0] v);
         return v < 0 ? -v : v;
      endfunction

      function automatic logic [63:0] root_floor(logic [63:0] s);
         logic [63:0] r;
         logic [63:0] b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Scales the vector so its largest magnitude lies in [2^29, 2^30), then divides.
      function automatic bit make_unit(input wvec_type v, output wvec_type u);
         logic [63:0] m[3];
         logic [63:0] big;
         logic [63:0] sum;
         logic [63:0] n;
         logic [63:0] q;
         int          len;
         big = 0;
         sum = 0;
         len = 0;
         u = '0;
         for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > big) big = m[i];
         end
         if (big == 0) return 0;
         while (len < 64 && (big >> len) != 0) len++;
         for (int i = 0; i < 3; i++) begin
            if (len > UnitBits) m[i] = m[i] >> (len - UnitBits);
            else m[i] = m[i] << (UnitBits - len);
            sum = sum + m[i] * m[i];
         end
         n = root_floor(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << UnitBits) + (n >> 1)) / n;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
         end
         return 1;
      endfunction

      function automatic wvec_type cross_vec(wvec_type a, wvec_type b);
         wvec_type c;
         c[0] = a[1] * b[2] - a[2] * b[1];
         c[1] = a[2] * b[0] - a[0] * b[2];
         c[2] = a[0] * b[1] - a[1] * b[0];
         return c;
      endfunction

      function void note_request(req_type r);
         wvec_type d, up, fwd, rc, rgt, uc, cup;
         rsp_type  e;
         bit       ok;
         d[0] = 64'(r.target_x) - 64'(r.eye_x);
         d[1] = 64'(r.target_y) - 64'(r.eye_y);
         d[2] = 64'(r.target_z) - 64'(r.eye_z);
         up[0] = 64'(r.up_dir_x);
         up[1] = 64'(r.up_dir_y);
         up[2] = 64'(r.up_dir_z);
         e = '0;
         ok = make_unit(d, fwd);
         if (ok) ok = make_unit(cross_vec(fwd, up), rgt);
         if (ok) ok = make_unit(cross_vec(rgt, fwd), cup);
         if (!ok) begin
            e.degenerate = 1'b1;
         end else begin
            e.right_x = rgt[0][31:0];
            e.right_y = rgt[1][31:0];
            e.right_z = rgt[2][31:0];
            e.cam_up_x = cup[0][31:0];
            e.cam_up_y = cup[1][31:0];
            e.cam_up_z = cup[2][31:0];
            e.back_x = 32'(-fwd[0]);
            e.back_y = 32'(-fwd[1]);
            e.back_z = 32'(-fwd[2]);
         end
         pending_rotations.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_rotations.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response beat %h", a);
            return;
         end
         e = pending_rotations.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: right exp %h %h %h got %h %h %h",
                        e.right_x, e.right_y, e.right_z, a.right_x, a.right_y, a.right_z);
               $display("  cam_up exp %h %h %h got %h %h %h",
                        e.cam_up_x, e.cam_up_y, e.cam_up_z, a.cam_up_x, a.cam_up_y, a.cam_up_z);
               $display("  back exp %h %h %h got %h %h %h, degenerate exp %b got %b",
                        e.back_x, e.back_y, e.back_z, a.back_x, a.back_y, a.back_z,
                        e.degenerate, a.degenerate);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rotation_scoreboard board;
   int unsigned        cycle_count;
   bit                 hold_rsp;
   bit                 sender_done;

   localparam int unsigned CycleLimit = 400000;

   camera_look_at_rotation_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Responses are checked at the rising edge at which they are taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // Receiver: random stall per beat, with one long hold-off on request.
   initial begin
      int gap;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
            hold_rsp = 0;
         end
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
         while (!(rsp_valid && !rsp_stall) && !hold_rsp) begin
            if (!rsp_valid) begin
               @(negedge clock);
            end else begin
               @(negedge clock);
            end
         end
      end
   end

   task automatic send_request(req_type r, bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed($urandom_range(0, 8)) - 4;
         3: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.eye_x = random_word();
      r.eye_y = random_word();
      r.eye_z = random_word();
      r.target_x = random_word();
      r.target_y = random_word();
      r.target_z = random_word();
      r.up_dir_x = random_word();
      r.up_dir_y = random_word();
      r.up_dir_z = random_word();
      case ($urandom_range(0, 9))
         // Target on the eye.
         0: begin
            r.target_x = r.eye_x;
            r.target_y = r.eye_y;
            r.target_z = r.eye_z;
         end
         // World up along the viewing direction.
         1: begin
            r.up_dir_x = r.target_x - r.eye_x;
            r.up_dir_y = r.target_y - r.eye_y;
            r.up_dir_z = r.target_z - r.eye_z;
         end
         2: r.up_dir_x = 0;
         3: begin
            r.up_dir_x = 0;
            r.up_dir_y = 32'sh0001_0000;
            r.up_dir_z = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type make_request(logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                             ux, uy, uz);
      req_type r;
      r = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return r;
   endfunction

   initial begin
      req_type directed[$];
      int      settle;
      board = new();
      cycle_count = 0;
      hold_rsp = 0;
      sender_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed.push_back(make_request(0, 0, 0, 0, 0, -32'sh10000, 0, 32'sh10000, 0));
      directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 32'sh10000, 0));
      directed.push_back(make_request(0, 0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0));
      directed.push_back(make_request(0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0));
      directed.push_back(make_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                      32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
      directed.push_back(make_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff));
      directed.push_back(make_request(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0,
                                      0, 0, 32'sh8000_0000));
      directed.push_back(make_request(0, 0, 0, 1, 0, 0, 0, 1, 0));
      directed.push_back(make_request(0, 0, 0, 1, 1, 1, -1, -1, -1));
      directed.push_back(make_request(0, 0, 0, 1, 0, 0, 1, 1, 0));
      directed.push_back(make_request(-1, -1, -1, -1, -1, -1, -1, -1, -1));
      directed.push_back(make_request(32'sh12345, -32'sh6789, 32'sh10, 32'sh7fff_0000,
                                      -32'sh7fff_0000, 32'sh3, 32'sh10000, 32'sh1, -32'sh1));
      foreach (directed[i]) send_request(directed[i], 1'b0);

      // Long receiver hold-off while requests keep coming, so req_stall rises.
      hold_rsp = 1;
      for (int i = 0; i < 500; i++) send_request(random_request(), i >= 300);

      // Sender pauses until the pipeline has drained.
      req_valid <= 1'b0;
      while (board.pending_rotations.size() != 0) @(negedge clock);

      for (int i = 0; i < 1500; i++) send_request(random_request(), $urandom_range(0, 7) != 0);
      req_valid <= 1'b0;

      while (board.pending_rotations.size() != 0) @(negedge clock);
      settle = 0;
      while (settle < 300) begin
         @(negedge clock);
         settle++;
      end
      if (board.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
